@@ hw/rtl/hasi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hasi_pkg
// Types, sizes and codes shared by the hashed address set blocks.
// ----------------------------------------------------------------------------
package hasi_pkg;

    localparam int MAX_ENTRIES = 4096;
    localparam int SLOT_COUNT  = 8192;
    localparam int PROBE_LIMIT = 32;

    localparam int ADDR_W   = 64;
    localparam int INDEX_W  = 12;
    localparam int STATUS_W = 3;
    localparam int DROP_W   = 32;

    localparam int SLOT_W   = $clog2(SLOT_COUNT);
    localparam int ENTRY_AW = $clog2(MAX_ENTRIES);
    localparam int COUNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int PK_W     = $clog2(PROBE_LIMIT + 1);

    localparam logic [31:0] HASH_MUL_LO = 32'd2654435761;
    localparam logic [31:0] HASH_MUL_HI = 32'd40503;
    localparam int          HI_SHIFT    = 32;
    localparam int          LO_SHIFT    = 4;

    localparam logic [COUNT_W-1:0] FULL_COUNT    = COUNT_W'(MAX_ENTRIES);
    localparam logic [PK_W-1:0]    PROBE_LIMIT_K = PK_W'(PROBE_LIMIT);
    localparam logic [DROP_W-1:0]  DROP_MAX      = '1;

    localparam logic [STATUS_W-1:0] ST_FOUND      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ADDED      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DROP_FULL  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DROP_PROBE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_READ_OK    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_READ_RANGE = 3'd5;

    localparam logic FUNC_REGISTER = 1'b0;
    localparam logic FUNC_READ     = 1'b1;

    typedef struct packed {
        logic               func;
        logic [ADDR_W-1:0]  address;
        logic [INDEX_W-1:0] entry_index;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  index;
        logic [ADDR_W-1:0]   stored_address;
        logic [COUNT_W-1:0]  stored_count;
        logic [DROP_W-1:0]   drop_count;
    } out_item_t;

    // slot_map read in flight / slot link resolved
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
        logic [PK_W-1:0]   k;
    } probe_b_t;

    // address_store compare in flight
    typedef struct packed {
        logic                valid;
        logic                cand;
        logic [ENTRY_AW-1:0] e;
    } probe_c_t;

endpackage

@@ hw/rtl/hasi_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hasi_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hasi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/hasi_hash.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hasi_hash
// Home slot of an address: two multiplicative hashes XORed, masked to slots.
// ----------------------------------------------------------------------------
module hasi_hash (
    input  logic [hasi_pkg::ADDR_W-1:0] address,
    output logic [hasi_pkg::SLOT_W-1:0] home
);

    localparam int SW = hasi_pkg::SLOT_W;

    // only the low SW bits of each 32-bit product survive the mask, and those
    // depend only on the low SW bits of the operands
    logic [SW-1:0] lo_op;
    logic [SW-1:0] hi_op;
    logic [SW-1:0] lo_prod;
    logic [SW-1:0] hi_prod;

    assign lo_op   = address[hasi_pkg::LO_SHIFT +: SW];
    assign hi_op   = address[hasi_pkg::HI_SHIFT +: SW];
    assign lo_prod = lo_op * hasi_pkg::HASH_MUL_LO[SW-1:0];
    assign hi_prod = hi_op * hasi_pkg::HASH_MUL_HI[SW-1:0];
    assign home    = lo_prod ^ hi_prod;

endmodule

@@ hw/rtl/hashed_address_set_insert.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_address_set_insert
// Deduplicating address set: linear-probe hash table over a slot map RAM and
// an address store RAM, with a read-back path by entry index.
// ----------------------------------------------------------------------------
//  channel | ports                      | beat
//  --------+----------------------------+-------------------------------------
//  input   | s_valid s_ready s_data     | func, address, entry_index
//  result  | m_valid m_ready m_data     | status, index, stored_address,
//          |                            | stored_count, drop_count
//
//  Register beat: accept, hash, then one slot_map read per cycle, pipelined
//  against the address_store compare, until a hit, an empty slot or the
//  PROBE_LIMIT ends the search. The single slot_map read port sets this rate.
//  Read beat: the address_store read, then the result load; the result load
//  alone when the index is out of range.
//  After reset the slot map is zeroed one slot per cycle, with s_ready low
//  until all SLOT_COUNT (8192) slots are clear. A held result does not
//  block the next accept; a finished item waits in a result register until
//  m_data is free.
// ----------------------------------------------------------------------------
module hashed_address_set_insert (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hasi_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output hasi_pkg::out_item_t m_data
);

    localparam int SLOT_W   = hasi_pkg::SLOT_W;
    localparam int ENTRY_AW = hasi_pkg::ENTRY_AW;
    localparam int COUNT_W  = hasi_pkg::COUNT_W;
    localparam int INDEX_W  = hasi_pkg::INDEX_W;
    localparam int ADDR_W   = hasi_pkg::ADDR_W;
    localparam int DROP_W   = hasi_pkg::DROP_W;
    localparam int PK_W     = hasi_pkg::PK_W;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_HASH   = 3'd2;
    localparam logic [2:0] S_PROBE  = 3'd3;
    localparam logic [2:0] S_RDWAIT = 3'd4;
    localparam logic [2:0] S_FLUSH  = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [SLOT_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [INDEX_W-1:0]  eidx_reg, eidx_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [DROP_W-1:0]   drop_reg, drop_next;
    hasi_pkg::probe_b_t  pb_reg, pb_next;
    hasi_pkg::probe_c_t  pc_reg, pc_next;
    hasi_pkg::out_item_t res_reg, res_next;
    hasi_pkg::out_item_t m_data_reg, m_data_next;
    logic                m_valid_reg, m_valid_next;

    logic                slot_we;
    logic [SLOT_W-1:0]   slot_waddr;
    logic [COUNT_W-1:0]  slot_wdata;
    logic [SLOT_W-1:0]   slot_raddr;
    logic [COUNT_W-1:0]  slot_rdata;

    logic                store_we;
    logic [ENTRY_AW-1:0] store_waddr;
    logic [ENTRY_AW-1:0] store_raddr;
    logic [ADDR_W-1:0]   store_rdata;

    logic [SLOT_W-1:0]   home;
    logic [COUNT_W-1:0]  link_e;
    logic                b_empty;
    logic                b_cand;
    logic                c_hit;
    logic [PK_W-1:0]     next_k;
    logic [DROP_W-1:0]   drop_inc;

    hasi_hash u_hash (
        .address (addr_reg),
        .home    (home)
    );

    hasi_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (hasi_pkg::SLOT_COUNT)
    ) u_slot_map (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    hasi_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (hasi_pkg::MAX_ENTRIES)
    ) u_addr_store (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (addr_reg),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    // slot link decode for the probe whose slot_map data is arriving now
    assign link_e   = slot_rdata - COUNT_W'(1);
    assign b_empty  = pb_reg.valid && (slot_rdata == '0);
    assign b_cand   = pb_reg.valid && (slot_rdata != '0) && (link_e < count_reg);
    assign c_hit    = pc_reg.valid && pc_reg.cand && (store_rdata == addr_reg);
    assign next_k   = pb_reg.k + PK_W'(1);
    assign drop_inc = (drop_reg == hasi_pkg::DROP_MAX) ? drop_reg : drop_reg + DROP_W'(1);

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        addr_next    = addr_reg;
        eidx_next    = eidx_reg;
        count_next   = count_reg;
        drop_next    = drop_reg;
        pb_next      = pb_reg;
        pc_next      = pc_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;

        slot_we     = 1'b0;
        slot_waddr  = pb_reg.slot;
        slot_wdata  = count_reg + COUNT_W'(1);
        slot_raddr  = pb_reg.slot + SLOT_W'(1);
        store_we    = 1'b0;
        store_waddr = count_reg[ENTRY_AW-1:0];
        store_raddr = link_e[ENTRY_AW-1:0];

        unique case (state_reg)
            S_CLEAR: begin
                slot_we      = 1'b1;
                slot_waddr   = clr_cnt_reg;
                slot_wdata   = '0;
                clr_cnt_next = clr_cnt_reg + SLOT_W'(1);
                if (clr_cnt_reg == SLOT_W'(hasi_pkg::SLOT_COUNT - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                store_raddr = s_data.entry_index[ENTRY_AW-1:0];
                if (s_valid) begin
                    addr_next = s_data.address;
                    eidx_next = s_data.entry_index;
                    if (s_data.func == hasi_pkg::FUNC_READ) begin
                        if (COUNT_W'(s_data.entry_index) < count_reg) begin
                            state_next = S_RDWAIT;
                        end else begin
                            res_next.status         = hasi_pkg::ST_READ_RANGE;
                            res_next.index          = '0;
                            res_next.stored_address = '0;
                            res_next.stored_count   = count_reg;
                            res_next.drop_count     = drop_reg;
                            state_next              = S_FLUSH;
                        end
                    end else begin
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH: begin
                slot_raddr    = home;
                pb_next.valid = 1'b1;
                pb_next.slot  = home;
                pb_next.k     = '0;
                pc_next.valid = 1'b0;
                state_next    = S_PROBE;
            end
            S_PROBE: begin
                res_next.stored_address = '0;
                res_next.stored_count   = count_reg;
                res_next.drop_count     = drop_reg;
                // older probe (compare stage) wins over the younger slot probe
                priority if (c_hit) begin
                    res_next.status = hasi_pkg::ST_FOUND;
                    res_next.index  = INDEX_W'(pc_reg.e);
                    state_next      = S_FLUSH;
                end else if (b_empty) begin
                    if (count_reg == hasi_pkg::FULL_COUNT) begin
                        res_next.status     = hasi_pkg::ST_DROP_FULL;
                        res_next.index      = '0;
                        drop_next           = drop_inc;
                        res_next.drop_count = drop_inc;
                    end else begin
                        slot_we               = 1'b1;
                        store_we              = 1'b1;
                        count_next            = count_reg + COUNT_W'(1);
                        res_next.status       = hasi_pkg::ST_ADDED;
                        res_next.index        = INDEX_W'(count_reg);
                        res_next.stored_count = count_reg + COUNT_W'(1);
                    end
                    state_next = S_FLUSH;
                end else if (!pb_reg.valid) begin
                    res_next.status     = hasi_pkg::ST_DROP_PROBE;
                    res_next.index      = '0;
                    drop_next           = drop_inc;
                    res_next.drop_count = drop_inc;
                    state_next          = S_FLUSH;
                end else begin
                    pc_next.valid = 1'b1;
                    pc_next.cand  = b_cand;
                    pc_next.e     = link_e[ENTRY_AW-1:0];
                    pb_next.valid = (next_k < hasi_pkg::PROBE_LIMIT_K);
                    pb_next.slot  = pb_reg.slot + SLOT_W'(1);
                    pb_next.k     = next_k;
                end
            end
            S_RDWAIT: begin
                res_next.status         = hasi_pkg::ST_READ_OK;
                res_next.index          = eidx_reg;
                res_next.stored_address = store_rdata;
                res_next.stored_count   = count_reg;
                res_next.drop_count     = drop_reg;
                state_next              = S_FLUSH;
            end
            S_FLUSH: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            count_reg   <= '0;
            drop_reg    <= '0;
            pb_reg      <= '0;
            pc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            count_reg   <= count_next;
            drop_reg    <= drop_next;
            pb_reg      <= pb_next;
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg   <= addr_next;
        eidx_reg   <= eidx_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= hasi_pkg::FULL_COUNT)
        else $error("entry count above capacity");

    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PROBE && slot_we) |=> count_reg == $past(count_reg) + COUNT_W'(1))
        else $error("insert did not advance entry count");

    a_result_from_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == S_FLUSH)
        else $error("result beat raised outside flush");

    a_added_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.status == hasi_pkg::ST_ADDED)
        |-> m_data_reg.stored_count == COUNT_W'(m_data_reg.index) + COUNT_W'(1))
        else $error("added entry index does not match stored count");

endmodule
